// ----- src/gmc_pkg.sv -----
// Shared constants for the global minimum cut core.
package gmc_pkg;

  localparam int GMC_MAX_VERTICES = 32;
  localparam int GMC_WEIGHT_BITS  = 16;
  localparam int GMC_W_BITS       = 24;
  localparam logic [GMC_W_BITS-1:0] GMC_W_MAX = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

endpackage

// ----- src/global_min_cut_core.sv -----
// Global minimum cut core: loads weighted edges, then runs Stoer-Wagner phases on one memory.
// An edge load reads the pair entry, checks it for an earlier weight and writes only if there is
// none. A start item runs n-1 phases for n vertices in use. A phase with r vertices left runs
// r-1 key sweeps and one merge sweep over the n vertex slots, with steps of setup and
// bookkeeping; the run time is set by the one read port that feeds the key sweep. The result
// then waits in an output register, and the weight memory (MAX_VERTICES^2 entries) is cleared
// one entry per cycle; the same clearing pass runs after reset. No item is accepted while a
// run or a clearing pass is under way.
// Configuration writes are always taken.
module global_min_cut_core
  import gmc_pkg::*;
#(
  parameter int MAX_VERTICES = GMC_MAX_VERTICES,
  parameter int WEIGHT_BITS  = GMC_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_vertex_count,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [4:0]  in_end_a,
  input  logic [4:0]  in_end_b,
  input  logic [15:0] in_edge_weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_cut_weight,
  output logic [31:0] out_side_mask
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int KW    = GMC_W_BITS + VW;
  localparam logic [15:0] WMASK =
    (WEIGHT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << WEIGHT_BITS) - 32'd1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LD, S_PH_INIT, S_STEP, S_PH_END, S_MERGE, S_MRG_FIX, S_DONE
  } state_t;

  function automatic logic [AW-1:0] pair_addr(input logic [VW-1:0] x, input logic [VW-1:0] y);
    pair_addr = (x > y) ? {x, y} : {y, x};
  endfunction

  state_t state_r;

  // weight memory, one entry per unordered vertex pair
  logic [GMC_W_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]         rd0_addr, rd1_addr, wr_addr;
  logic [GMC_W_BITS-1:0] rd0_data_r, rd1_data_r, wr_data;
  logic                  wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd0_data_r <= mem[rd0_addr];
    rd1_data_r <= mem[rd1_addr];
  end

  logic [5:0]            vcount_r;
  logic [NW-1:0]         n_r, rem_r, step_r, v_r;
  logic [VW-1:0]         p_v_r, last_r, prev_r, pick_r;
  logic                  p_ok_r, pick_found_r, first_r;
  logic [KW-1:0]         pick_key_r;
  logic [KW-1:0]         key_r [MAX_VERTICES];
  logic [VW-1:0]         owner_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] act_r, in_set_r;
  logic [AW-1:0]         clr_r, ld_addr_r;
  logic [GMC_W_BITS-1:0] ld_w_r, best_cut_r;
  logic [31:0]           best_mask_r;
  logic                  ld_ok_r;
  logic                  out_valid_r;
  logic [23:0]           out_cut_r;
  logic [31:0]           out_mask_r;

  logic            in_acc;
  logic [VW-1:0]   a_ix, b_ix, v_ix, start_ix;
  logic            ld_ok;
  logic [NW-1:0]   n_clamp;
  logic [KW-1:0]   nkey;
  logic [GMC_W_BITS:0] msum;
  logic [GMC_W_BITS-1:0] cut;
  logic [31:0]     last_mask;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_cut_weight = out_cut_r;
  assign out_side_mask  = out_mask_r;

  assign a_ix  = VW'(in_end_a);
  assign b_ix  = VW'(in_end_b);
  assign ld_ok = (in_end_a != in_end_b) && (int'(in_end_a) < MAX_VERTICES) &&
                 (int'(in_end_b) < MAX_VERTICES);
  assign v_ix  = v_r[VW-1:0];

  always_comb begin
    if (vcount_r < 6'd2) n_clamp = NW'(2);
    else if (int'(vcount_r) > MAX_VERTICES) n_clamp = NW'(MAX_VERTICES);
    else n_clamp = NW'(vcount_r);
  end

  // phase start: vertex 1 if still active, else lowest active
  always_comb begin
    start_ix = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--)
      if (act_r[i]) start_ix = VW'(i);
    if (act_r[1]) start_ix = VW'(1);
  end

  always_comb begin
    for (int i = 0; i < 32; i++)
      last_mask[i] = (i < MAX_VERTICES) ? (owner_r[i % MAX_VERTICES] == last_r) : 1'b0;
  end

  assign nkey = key_r[p_v_r] + KW'(rd0_data_r);
  assign msum = {1'b0, rd0_data_r} + {1'b0, rd1_data_r};
  assign cut  = (|pick_key_r[KW-1:GMC_W_BITS]) ? GMC_W_MAX : pick_key_r[GMC_W_BITS-1:0];

  // memory port control
  always_comb begin
    rd0_addr = pair_addr(last_r, v_ix);
    rd1_addr = pair_addr(prev_r, v_ix);
    wr_en    = 1'b0;
    wr_addr  = clr_r;
    wr_data  = '0;
    case (state_r)
      S_CLR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        rd0_addr = pair_addr(a_ix, b_ix);
      end
      S_LD: begin
        wr_en   = ld_ok_r && (rd0_data_r == '0);
        wr_addr = ld_addr_r;
        wr_data = ld_w_r;
      end
      S_MERGE: begin
        wr_en   = p_ok_r && act_r[p_v_r] && (p_v_r != prev_r) && (p_v_r != last_r);
        wr_addr = pair_addr(prev_r, p_v_r);
        wr_data = msum[GMC_W_BITS] ? GMC_W_MAX : msum[GMC_W_BITS-1:0];
      end
      S_MRG_FIX: begin
        wr_en   = 1'b1;
        wr_addr = pair_addr(prev_r, last_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      vcount_r    <= 6'd2;
      out_valid_r <= 1'b0;
      act_r       <= '0;
      in_set_r    <= '0;
      p_ok_r      <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) owner_r[i] <= VW'(i);
    end else begin
      if (cfg_we) vcount_r <= cfg_vertex_count;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (int'(clr_r) == DEPTH - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_cmd == CMD_LOAD) begin
              ld_addr_r <= pair_addr(a_ix, b_ix);
              ld_w_r    <= GMC_W_BITS'(in_edge_weight & WMASK);
              ld_ok_r   <= ld_ok;
              state_r   <= S_LD;
            end else begin
              n_r        <= n_clamp;
              rem_r      <= n_clamp;
              first_r    <= 1'b1;
              best_cut_r <= GMC_W_MAX;
              best_mask_r <= '0;
              for (int i = 0; i < MAX_VERTICES; i++) act_r[i] <= (i < int'(n_clamp));
              state_r    <= S_PH_INIT;
            end
          end
        end
        S_LD: begin
          state_r <= S_IDLE;
        end
        S_PH_INIT: begin
          for (int i = 0; i < MAX_VERTICES; i++) key_r[i] <= '0;
          in_set_r           <= MAX_VERTICES'(1) << start_ix;
          last_r             <= start_ix;
          prev_r             <= start_ix;
          step_r             <= NW'(1);
          v_r                <= '0;
          p_ok_r             <= 1'b0;
          pick_found_r       <= 1'b0;
          state_r            <= S_STEP;
        end
        S_STEP: begin
          p_v_r  <= v_ix;
          p_ok_r <= (v_r < n_r);
          if (v_r < n_r) v_r <= v_r + NW'(1);
          if (p_ok_r && act_r[p_v_r] && !in_set_r[p_v_r]) begin
            key_r[p_v_r] <= nkey;
            if (!pick_found_r || nkey > pick_key_r) begin
              pick_found_r <= 1'b1;
              pick_r       <= p_v_r;
              pick_key_r   <= nkey;
            end
          end
          if (v_r == n_r && !p_ok_r) begin
            prev_r           <= last_r;
            last_r           <= pick_r;
            in_set_r[pick_r] <= 1'b1;
            v_r              <= '0;
            pick_found_r     <= 1'b0;
            step_r           <= step_r + NW'(1);
            if (step_r == rem_r - NW'(1)) state_r <= S_PH_END;
          end
        end
        S_PH_END: begin
          if (first_r || cut < best_cut_r) begin
            best_cut_r  <= cut;
            best_mask_r <= last_mask;
          end
          first_r <= 1'b0;
          v_r     <= '0;
          p_ok_r  <= 1'b0;
          state_r <= S_MERGE;
        end
        S_MERGE: begin
          p_v_r  <= v_ix;
          p_ok_r <= (v_r < n_r);
          if (v_r < n_r) v_r <= v_r + NW'(1);
          if (v_r == n_r && !p_ok_r) state_r <= S_MRG_FIX;
        end
        S_MRG_FIX: begin
          for (int i = 0; i < MAX_VERTICES; i++)
            if (owner_r[i] == last_r) owner_r[i] <= prev_r;
          act_r[last_r] <= 1'b0;
          rem_r         <= rem_r - NW'(1);
          state_r       <= (rem_r == NW'(2)) ? S_DONE : S_PH_INIT;
        end
        S_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_cut_r   <= best_cut_r;
            out_mask_r  <= best_mask_r;
            clr_r       <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) owner_r[i] <= VW'(i);
            state_r     <= S_CLR;
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  // a result appears only at the end of a run
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside run end");

  // weight memory is never written while items are being taken
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("memory write while idle");

  // a phase always has at least two vertices left
  a_rem_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP || state_r == S_MERGE) |-> (rem_r >= NW'(2)))
    else $error("phase with too few vertices");

endmodule
